FILE: rtl/dtdq_pkg.sv
// Shared types and constants of the dwell-time threshold qualifier.
// Used by every module of the block; has no dependencies of its own.
package dtdq_pkg;

    // Sensor count and the number of sensors actually watched
    localparam int NUM_SENSORS = 16;
    localparam int WATCHED     = (NUM_SENSORS < 16) ? NUM_SENSORS : 16;
    localparam int SENS_W      = (WATCHED > 1) ? $clog2(WATCHED) : 1;

    // Field widths
    localparam int IDX_W     = 4;
    localparam int VALUE_W   = 32;
    localparam int DWELL_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL     = 2'd1;

    // Command queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // Classified command passed from front to back
    typedef struct packed {
        logic              op;
        logic [SENS_W-1:0] idx;
        logic              match;
    } t_cmd;

endpackage

FILE: rtl/dtdq_front.sv
// Front end: accepts input transfers, compares samples against the threshold
// and drops samples of unwatched sensors. Depends on dtdq_pkg.
module dtdq_front (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [dtdq_pkg::IDX_W-1:0]    i_sensor_index,
    input  logic [dtdq_pkg::VALUE_W-1:0]  i_sample_value,
    input  logic [dtdq_pkg::VALUE_W-1:0]  i_threshold,
    input  logic                          i_q_full,
    output logic                          o_push,
    output dtdq_pkg::t_cmd                o_cmd
);

    logic w_in_range;

    // Accept whenever the queue has room
    assign o_ready = !i_q_full;

    // Drop samples of sensors beyond the watched range
    assign w_in_range = (int'(i_sensor_index) < dtdq_pkg::WATCHED);

    assign o_push = i_valid && !i_q_full
                    && ((i_op == dtdq_pkg::OP_TICK) || w_in_range);

    // Classify the item
    always_comb begin
        o_cmd.op    = i_op;
        o_cmd.idx   = i_sensor_index[dtdq_pkg::SENS_W-1:0];
        o_cmd.match = (i_sample_value == i_threshold);
    end

endmodule

FILE: rtl/dtdq_cmd_fifo.sv
// Short command queue between front and back ends.
// Depends on dtdq_pkg for the command type and depth.
module dtdq_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtdq_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output dtdq_pkg::t_cmd  o_cmd
);

    dtdq_pkg::t_cmd                r_mem [dtdq_pkg::QDEPTH];
    logic [dtdq_pkg::QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [dtdq_pkg::QPTR_W:0]     r_count;

    assign o_full  = (r_count == (dtdq_pkg::QPTR_W+1)'(dtdq_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/dtdq_back.sv
// Back end: holds per-sensor countdowns, executes samples and walks all
// countdowns on a tick, driving the registered result channel. Depends on dtdq_pkg.
module dtdq_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  dtdq_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    input  logic [dtdq_pkg::DWELL_W-1:0]  i_dwell_ticks,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dtdq_pkg::IDX_W-1:0]    o_fired_sensor,
    output logic                          o_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam logic [dtdq_pkg::SENS_W-1:0] LAST_SENSOR =
        dtdq_pkg::SENS_W'(dtdq_pkg::WATCHED - 1);

    logic [1:0]                    r_state, n_state;
    logic [dtdq_pkg::SENS_W-1:0]   r_cnt, n_cnt;
    logic                          r_pend_valid, n_pend_valid;
    logic [dtdq_pkg::SENS_W-1:0]   r_pend, n_pend;
    logic                          r_dwell [dtdq_pkg::WATCHED];
    logic                          n_dwell [dtdq_pkg::WATCHED];
    logic [dtdq_pkg::DWELL_W-1:0]  r_rem [dtdq_pkg::WATCHED];
    logic [dtdq_pkg::DWELL_W-1:0]  n_rem [dtdq_pkg::WATCHED];
    logic                          r_out_valid;
    logic [dtdq_pkg::SENS_W-1:0]   r_out_sensor;
    logic                          r_out_last;

    logic                          w_out_free;
    logic                          w_push;
    logic [dtdq_pkg::SENS_W-1:0]   w_push_sensor;
    logic                          w_push_last;
    logic [dtdq_pkg::SENS_W-1:0]   w_addr;
    logic [dtdq_pkg::DWELL_W-1:0]  w_dec;

    assign w_out_free = !r_out_valid || i_ready;

    // One countdown is read per cycle: the sample's sensor or the scan position
    assign w_addr = (r_state == ST_SCAN) ? r_cnt : i_cmd.idx;
    assign w_dec  = (r_rem[w_addr] != '0) ? (r_rem[w_addr] - 1'b1) : '0;

    // Sequence commands and countdown walk
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_pend_valid  = r_pend_valid;
        n_pend        = r_pend;
        n_dwell       = r_dwell;
        n_rem         = r_rem;
        o_pop         = 1'b0;
        w_push        = 1'b0;
        w_push_sensor = r_pend;
        w_push_last   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == dtdq_pkg::OP_SAMPLE) begin
                        if (r_dwell[w_addr] && !i_cmd.match) begin
                            // Cancel a running countdown
                            n_dwell[w_addr] = 1'b0;
                            n_rem[w_addr]   = '0;
                            o_pop           = 1'b1;
                        end else if (i_cmd.match) begin
                            if (i_dwell_ticks == '0) begin
                                // Fire at once, leave any countdown alone
                                if (w_out_free) begin
                                    w_push        = 1'b1;
                                    w_push_sensor = i_cmd.idx;
                                    w_push_last   = 1'b1;
                                    o_pop         = 1'b1;
                                end
                            end else begin
                                // Arm or re-arm
                                n_dwell[w_addr] = 1'b1;
                                n_rem[w_addr]   = i_dwell_ticks;
                                o_pop           = 1'b1;
                            end
                        end else begin
                            o_pop = 1'b1;
                        end
                    end else begin
                        n_cnt        = '0;
                        n_pend_valid = 1'b0;
                        n_state      = ST_SCAN;
                        o_pop        = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (r_dwell[w_addr] && (w_dec == '0) && r_pend_valid && !w_out_free) begin
                    // Hold until the previous firing can be sent
                    n_state = ST_SCAN;
                end else begin
                    if (r_dwell[w_addr]) begin
                        n_rem[w_addr] = w_dec;
                        if (w_dec == '0) begin
                            // Send the previous firing, keep this one pending
                            w_push          = r_pend_valid;
                            n_pend          = r_cnt;
                            n_pend_valid    = 1'b1;
                            n_dwell[w_addr] = 1'b0;
                        end
                    end
                    if (r_cnt == LAST_SENSOR) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                // Send the final firing of the tick with last set
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    w_push       = 1'b1;
                    w_push_last  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and countdowns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < dtdq_pkg::WATCHED; i++) begin
                r_dwell[i] <= 1'b0;
                r_rem[i]   <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_dwell      <= n_dwell;
            r_rem        <= n_rem;
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_pend <= n_pend;
        if (w_push) begin
            r_out_sensor <= w_push_sensor;
            r_out_last   <= w_push_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_fired_sensor = dtdq_pkg::IDX_W'(r_out_sensor);
    assign o_last         = r_out_last;

endmodule

FILE: rtl/discrete_threshold_dwell_qualifier_core.sv
// Dwell-time threshold qualifier: top level with configuration registers.
// Depends on dtdq_pkg, dtdq_front, dtdq_cmd_fifo and dtdq_back.
// Order: a sample passes through the command queue, then the result register; a tick's
// firings follow the walk, each held back until the next one is found or the walk ends.
// Throughput: one sample per cycle when nothing stalls; a tick occupies the back end.
// Reset (synchronous, active low) clears registers, countdowns, queue and outputs.
module discrete_threshold_dwell_qualifier_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [dtdq_pkg::IDX_W-1:0]      i_sensor_index,
    input  logic [dtdq_pkg::VALUE_W-1:0]    i_sample_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [dtdq_pkg::IDX_W-1:0]      o_fired_sensor,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dtdq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dtdq_pkg::VALUE_W-1:0]    i_cfg_data
);

    logic [dtdq_pkg::VALUE_W-1:0]  r_threshold;
    logic [dtdq_pkg::DWELL_W-1:0]  r_dwell_ticks;
    logic                          w_q_full;
    logic                          w_push;
    dtdq_pkg::t_cmd                w_push_cmd;
    logic                          w_q_valid;
    logic                          w_pop;
    dtdq_pkg::t_cmd                w_q_cmd;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= '0;
            r_dwell_ticks <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dtdq_pkg::CFG_THRESHOLD: r_threshold   <= i_cfg_data;
                dtdq_pkg::CFG_DWELL:     r_dwell_ticks <= i_cfg_data[dtdq_pkg::DWELL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dtdq_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_sensor_index (i_sensor_index),
        .i_sample_value (i_sample_value),
        .i_threshold    (r_threshold),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    dtdq_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd)
    );

    dtdq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_q_valid),
        .i_cmd          (w_q_cmd),
        .o_pop          (w_pop),
        .i_dwell_ticks  (r_dwell_ticks),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_fired_sensor (o_fired_sensor),
        .o_last         (o_last)
    );

endmodule

FILE: sim/dtdq_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the dwell-time threshold qualifier: watches the sample, result and
// register channels, predicts each sensor fire and compares the results in order.
// Depends on dtdq_pkg for widths, item kinds and register indexes.
module dtdq_checker
    import dtdq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_in_op,
    input  logic [IDX_W-1:0]     i_in_sensor,
    input  logic [VALUE_W-1:0]   i_in_value,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [IDX_W-1:0]     i_out_sensor,
    input  logic                 i_out_last,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VALUE_W-1:0]   i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int PRINT_CAP = 50;

    typedef struct {
        logic [IDX_W-1:0] sensor;
        logic             last;
    } t_fire;

    // Shadow registers and per-sensor countdowns
    logic [VALUE_W-1:0] level;
    logic [DWELL_W-1:0] dwell;
    logic               dwelling [WATCHED];
    logic [DWELL_W-1:0] countdown [WATCHED];

    t_fire fires_due [$];
    int    mismatch_count;

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Advance the countdown state for one item and queue the fires it causes
    task automatic qualify_item(input logic op, input logic [IDX_W-1:0] idx,
                                input logic [VALUE_W-1:0] value);
        logic               hit;
        logic [WATCHED-1:0] fired;
        int                 s;
        t_fire              f;
        hit   = (value == level);
        fired = '0;
        if (op == OP_SAMPLE) begin
            if (idx < WATCHED) begin
                if (dwelling[idx] && !hit) begin
                    dwelling[idx]  = 1'b0;
                    countdown[idx] = '0;
                end else if (hit) begin
                    if (dwell == '0) begin
                        fired[idx] = 1'b1;
                    end else begin
                        dwelling[idx]  = 1'b1;
                        countdown[idx] = dwell;
                    end
                end
            end
        end else begin
            for (s = 0; s < WATCHED; s++) begin
                if (dwelling[s]) begin
                    if (countdown[s] != '0)
                        countdown[s] = countdown[s] - 1'b1;
                    if (countdown[s] == '0) begin
                        dwelling[s] = 1'b0;
                        fired[s]    = 1'b1;
                    end
                end
            end
        end
        // Fires come out in ascending sensor order, last on the highest one
        for (s = 0; s < WATCHED; s++) begin
            if (fired[s]) begin
                f.sensor = s[IDX_W-1:0];
                f.last   = ((fired >> (s + 1)) == '0);
                fires_due.push_back(f);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_fire due;
        int    s;
        if (!i_rst_n) begin
            level = '0;
            dwell = '0;
            for (s = 0; s < WATCHED; s++) begin
                dwelling[s]  = 1'b0;
                countdown[s] = '0;
            end
            fires_due.delete();
            mismatch_count = 0;
        end else begin
            // Compare a result transfer against the oldest fire due
            if (i_out_valid && i_out_ready) begin
                if (fires_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected fire of sensor %0d last %0b",
                                              i_out_sensor, i_out_last));
                end else begin
                    due = fires_due.pop_front();
                    if (i_out_sensor !== due.sensor)
                        report_mismatch($sformatf("fired_sensor %0d, expected %0d",
                                                  i_out_sensor, due.sensor));
                    if (i_out_last !== due.last)
                        report_mismatch($sformatf("last %0b on sensor %0d, expected %0b",
                                                  i_out_last, due.sensor, due.last));
                end
            end
            // Track register writes; unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_THRESHOLD)
                    level = i_cfg_data;
                else if (i_cfg_index == CFG_DWELL)
                    dwell = i_cfg_data[DWELL_W-1:0];
            end
            // Predict fires for an accepted item
            if (i_in_valid && i_in_ready)
                qualify_item(i_in_op, i_in_sensor, i_in_value);
        end
        o_errors  <= mismatch_count;
        o_pending <= fires_due.size();
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the dwell-time threshold qualifier: clock, reset, stimulus,
// random stalls on both sides and the verdict. Depends on dtdq_pkg, the block and
// dtdq_checker.
module tb_top;
    import dtdq_pkg::*;

    localparam int TAIL_CYCLES = 4 * (WATCHED + 1);
    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASE_ITEMS = 38;
    localparam int NUM_PHASES  = 5;

    // Unmapped register indexes, written to confirm they are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_ready;
    logic                 i_op           = OP_SAMPLE;
    logic [IDX_W-1:0]     i_sensor_index = '0;
    logic [VALUE_W-1:0]   i_sample_value = '0;
    logic                 o_valid;
    logic                 i_ready        = 1'b0;
    logic [IDX_W-1:0]     o_fired_sensor;
    logic                 o_last;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [VALUE_W-1:0]   i_cfg_data     = '0;

    int                   errors;
    int                   pending;
    int                   idle_cycles    = 0;
    int                   ready_run      = 0;
    logic                 item_up        = 1'b0;
    logic [VALUE_W-1:0]   match_level    = '0;

    discrete_threshold_dwell_qualifier_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_sensor_index (i_sensor_index),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_fired_sensor (o_fired_sensor),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    dtdq_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_op      (i_op),
        .i_in_sensor  (i_sensor_index),
        .i_in_value   (i_sample_value),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_sensor (o_fired_sensor),
        .i_out_last   (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Alternate runs of ready with random stalls on the result side
    always @(posedge i_clk) begin : ready_gen
        int stall;
        if (ready_run != 0) begin
            ready_run <= ready_run - 1;
        end else begin
            stall = gap_len();
            if (i_ready && stall != 0) begin
                i_ready   <= 1'b0;
                ready_run <= stall - 1;
            end else begin
                i_ready   <= 1'b1;
                ready_run <= $urandom_range(0, 30);
            end
        end
    end

    // Drop the run if no transfer happens on any channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Present one item after a random gap and hold it until the transfer
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [VALUE_W-1:0] value);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            if (item_up)
                i_valid <= 1'b0;
            item_up = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= op;
        i_sensor_index <= idx;
        i_sample_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        item_up = 1'b1;
    endtask

    task automatic send_sample(input logic [IDX_W-1:0] idx, input logic [VALUE_W-1:0] value);
        send_item(OP_SAMPLE, idx, value);
    endtask

    // Tick payload is junk on purpose: the block must ignore it
    task automatic send_tick();
        send_item(OP_TICK, IDX_W'($urandom_range(0, (1 << IDX_W) - 1)), $urandom);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_THRESHOLD)
            match_level = data;
    endtask

    // Drop valid, wait for every fire due, then let a silent tick walk finish
    task automatic settle();
        if (item_up)
            i_valid <= 1'b0;
        item_up = 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Mostly matching samples so countdowns arm, plus ticks, near misses and noise
    task automatic random_item();
        int                 pick;
        logic [VALUE_W-1:0] value;
        pick  = $urandom_range(0, 99);
        value = $urandom;
        if (pick < 30) begin
            send_tick();
        end else begin
            if (pick < 72)
                value = match_level;
            else if (pick < 80)
                value = match_level ^ (32'd1 << $urandom_range(0, VALUE_W - 1));
            send_sample(IDX_W'($urandom_range(0, (1 << IDX_W) - 1)), value);
        end
    endtask

    initial begin : stimulus
        int phase;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero dwell: matches fire at once; spare indexes must not disturb the registers
        write_reg(CFG_THRESHOLD, 32'd5);
        write_reg(CFG_DWELL, 32'd0);
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h1234_5678);
        send_sample(4'd0, 32'd5);
        send_sample(4'd15, 32'd5);
        send_sample(4'd3, 32'd6);
        send_tick();
        settle();

        // Arm, re-arm, cancel and expire at the most negative threshold
        write_reg(CFG_THRESHOLD, VAL_MIN);
        write_reg(CFG_DWELL, 32'd2);
        send_sample(4'd2, VAL_MIN);
        send_sample(4'd7, VAL_MIN);
        send_sample(4'd9, VAL_MAX);
        send_tick();
        send_sample(4'd2, VAL_MIN);
        send_sample(4'd7, 32'd0);
        send_tick();
        send_tick();
        send_sample(4'd4, VAL_MIN);
        settle();

        // Zero dwell while sensor 4 counts down: fire now, countdown keeps running
        write_reg(CFG_DWELL, 32'd0);
        send_sample(4'd4, VAL_MIN);
        send_tick();
        send_tick();
        settle();

        // Longest dwell: arm, tick once, cancel
        write_reg(CFG_THRESHOLD, VAL_MAX);
        write_reg(CFG_DWELL, 32'h0000_FFFF);
        send_sample(4'd1, VAL_MAX);
        send_tick();
        send_sample(4'd1, VAL_MIN);
        settle();

        // One-tick dwell: several sensors expire on the same tick
        write_reg(CFG_DWELL, 32'd1);
        send_sample(4'd0, VAL_MAX);
        send_sample(4'd5, VAL_MAX);
        send_sample(4'd10, VAL_MAX);
        send_sample(4'd15, VAL_MAX);
        send_tick();

        // Random phases over several register settings
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_reg(CFG_THRESHOLD, $urandom);
                    write_reg(CFG_DWELL, $urandom_range(1, 3));
                end
                1: begin
                    write_reg(CFG_THRESHOLD, VAL_MAX);
                    write_reg(CFG_DWELL, 32'd0);
                end
                2: begin
                    write_reg(CFG_THRESHOLD, VAL_MIN);
                    write_reg(CFG_DWELL, 32'd1);
                end
                3: begin
                    write_reg(CFG_THRESHOLD, $urandom);
                    write_reg(CFG_DWELL, $urandom_range(2, 6));
                end
                default: begin
                    write_reg(CFG_THRESHOLD, 32'd0);
                    write_reg(CFG_DWELL, $urandom_range(1, 2));
                end
            endcase
            repeat (PHASE_ITEMS) random_item();
        end
        settle();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dtdq_pkg.sv
rtl/dtdq_front.sv
rtl/dtdq_cmd_fifo.sv
rtl/dtdq_back.sv
rtl/discrete_threshold_dwell_qualifier_core.sv
sim/dtdq_checker.sv
sim/tb_top.sv
